@@ rtl/core/dadd_pkg.sv @@
// Shared types and constants for the Gregorian date-plus-days block.
// No dependencies; imported by every other file of the block.
package dadd_pkg;

    localparam int unsigned C_DAY_W   = 5;
    localparam int unsigned C_MONTH_W = 4;
    localparam int unsigned C_YEAR_W  = 14;
    localparam int unsigned C_ADD_W   = 15;
    localparam int unsigned C_ACC_W   = 16;
    localparam int unsigned C_YMOD_W  = 9;

    localparam logic [C_MONTH_W-1:0] C_FIRST_MONTH = 4'd1;
    localparam logic [C_MONTH_W-1:0] C_FEB         = 4'd2;
    localparam logic [C_MONTH_W-1:0] C_LAST_MONTH  = 4'd12;

    localparam logic [C_ACC_W-1:0]  C_YEAR_CYCLE = 16'd400;
    localparam logic [C_YEAR_W-1:0] C_YMOD_LAST  = 14'd399;
    localparam logic [C_YMOD_W-1:0] C_CENT_1     = 9'd100;
    localparam logic [C_YMOD_W-1:0] C_CENT_2     = 9'd200;
    localparam logic [C_YMOD_W-1:0] C_CENT_3     = 9'd300;

    localparam logic [C_DAY_W-1:0] C_FEB_LEAP = 5'd29;
    localparam logic [C_DAY_W-1:0] C_FEB_NORM = 5'd28;

    localparam logic [C_DAY_W-1:0] C_MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic [C_ACC_W-1:0]   a;
        logic [C_ACC_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [C_ACC_W-1:0] res;
        logic               borrow;
        logic               zero;
    } t_alu_rsp;

endpackage

@@ rtl/core/dadd_if.sv @@
// Handshake channels for the date-plus-days block: input date beat and result beat.
// Depends on dadd_pkg for field widths.
interface dadd_in_if
    import dadd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [C_DAY_W-1:0]   start_day;
    logic [C_MONTH_W-1:0] start_month;
    logic [C_YEAR_W-1:0]  start_year;
    logic [C_ADD_W-1:0]   days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                    output ready);
endinterface

interface dadd_out_if
    import dadd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [C_DAY_W-1:0]   result_day;
    logic [C_MONTH_W-1:0] result_month;
    logic [C_YEAR_W-1:0]  result_year;

    modport source (output valid, result_day, result_month, result_year, input ready);
    modport sink   (input valid, result_day, result_month, result_year, output ready);
endinterface

@@ rtl/core/gregorian_date_add_days.sv @@
// Top level: sequencer that drives one shared add/subtract unit to add days to a date.
// Depends on dadd_pkg, dadd_if, dadd_alu and dadd_mlen.
//
//   channel   dir   modport   payload
//   i_in      in    sink      start_day, start_month, start_year, days_to_add
//   o_out     out   source    result_day, result_month, result_year
//
// One beat in, one beat out. An item loads the start day plus days_to_add, reduces
// the year modulo 400 by repeated subtraction, sums the months before the start
// month, walks one month per cycle until the remainder fits the month, and then
// loads the result. All steps share the one add/subtract unit. i_in.ready is high
// only while idle. A stalled result holds in the output register. Reset is
// synchronous, active low, and clears the sequencer and result valid.
module gregorian_date_add_days
    import dadd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dadd_in_if.sink     i_in,
    dadd_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SUM,
        S_WALK,
        S_FIN
    } t_state;

    t_state                r_state,  n_state;
    logic [C_ACC_W-1:0]    r_rem,    n_rem;
    logic [C_YEAR_W:0]     r_year,   n_year;
    logic [C_YEAR_W-1:0]   r_ymod,   n_ymod;
    logic [C_MONTH_W-1:0]  r_m,      n_m;
    logic [C_MONTH_W-1:0]  r_mstart, n_mstart;
    logic                  r_ovalid, n_ovalid;
    logic [C_DAY_W-1:0]    r_oday,   n_oday;
    logic [C_MONTH_W-1:0]  r_omonth, n_omonth;
    logic [C_YEAR_W-1:0]   r_oyear,  n_oyear;

    t_alu_req              w_req;
    t_alu_rsp              w_rsp;
    logic [C_DAY_W-1:0]    w_len;

    dadd_mlen u_mlen (
        .i_month (r_m),
        .i_ymod  (r_ymod[C_YMOD_W-1:0]),
        .o_len   (w_len)
    );

    dadd_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_req.op = ALU_ADD;
                w_req.a  = {{(C_ACC_W-C_DAY_W){1'b0}}, i_in.start_day};
                w_req.b  = {{(C_ACC_W-C_ADD_W){1'b0}}, i_in.days_to_add};
            end
            S_MOD: begin
                w_req.op = ALU_SUB;
                w_req.a  = {{(C_ACC_W-C_YEAR_W){1'b0}}, r_ymod};
                w_req.b  = C_YEAR_CYCLE;
            end
            S_SUM: begin
                w_req.op = ALU_ADD;
                w_req.a  = r_rem;
                w_req.b  = {{(C_ACC_W-C_DAY_W){1'b0}}, w_len};
            end
            default: begin
                w_req.op = ALU_SUB;
                w_req.a  = r_rem;
                w_req.b  = {{(C_ACC_W-C_DAY_W){1'b0}}, w_len};
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_year   = r_year;
        n_ymod   = r_ymod;
        n_m      = r_m;
        n_mstart = r_mstart;
        n_ovalid = r_ovalid;
        n_oday   = r_oday;
        n_omonth = r_omonth;
        n_oyear  = r_oyear;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_rem    = w_rsp.res;
                    n_year   = {1'b0, i_in.start_year};
                    n_ymod   = i_in.start_year;
                    n_m      = C_FIRST_MONTH;
                    n_mstart = i_in.start_month;
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                if (!w_rsp.borrow) begin
                    n_ymod = w_rsp.res[C_YEAR_W-1:0];
                end else begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_m < r_mstart) begin
                    n_rem = w_rsp.res;
                    n_m   = r_m + C_FIRST_MONTH;
                end else begin
                    n_m     = C_FIRST_MONTH;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!w_rsp.borrow && !w_rsp.zero) begin
                    n_rem = w_rsp.res;
                    if (r_m == C_LAST_MONTH) begin
                        n_m    = C_FIRST_MONTH;
                        n_year = r_year + {{C_YEAR_W{1'b0}}, 1'b1};
                        n_ymod = (r_ymod == C_YMOD_LAST) ? '0
                               : r_ymod + {{(C_YEAR_W-1){1'b0}}, 1'b1};
                    end else begin
                        n_m = r_m + C_FIRST_MONTH;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oday   = r_rem[C_DAY_W-1:0];
                    n_omonth = r_m;
                    n_oyear  = r_year[C_YEAR_W-1:0];
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_rem    <= n_rem;
        r_year   <= n_year;
        r_ymod   <= n_ymod;
        r_m      <= n_m;
        r_mstart <= n_mstart;
        r_oday   <= n_oday;
        r_omonth <= n_omonth;
        r_oyear  <= n_oyear;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.result_day   = r_oday;
    assign o_out.result_month = r_omonth;
    assign o_out.result_year  = r_oyear;

endmodule

@@ rtl/core/dadd_alu.sv @@
// Shared 16-bit add/subtract unit with borrow and zero flags.
// Depends on dadd_pkg for the request and response structs.
module dadd_alu
    import dadd_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [C_ACC_W:0] w_sum;

    always_comb begin
        if (i_req.op == ALU_ADD) begin
            w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end else begin
            w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end
    end

    assign o_rsp.res    = w_sum[C_ACC_W-1:0];
    assign o_rsp.borrow = w_sum[C_ACC_W];
    assign o_rsp.zero   = (w_sum[C_ACC_W-1:0] == '0);

endmodule

@@ rtl/core/dadd_mlen.sv @@
// Month length lookup with the Gregorian leap rule taken from the year modulo 400.
// Depends on dadd_pkg for the month table and constants.
module dadd_mlen
    import dadd_pkg::*;
(
    input  logic [C_MONTH_W-1:0] i_month,
    input  logic [C_YMOD_W-1:0]  i_ymod,
    output logic [C_DAY_W-1:0]   o_len
);

    logic                 w_leap;
    logic [C_MONTH_W-1:0] w_idx;

    assign w_leap = (i_ymod == '0) ||
                    ((i_ymod[1:0] == 2'b00) && (i_ymod != C_CENT_1) &&
                     (i_ymod != C_CENT_2) && (i_ymod != C_CENT_3));
    assign w_idx  = i_month - C_FIRST_MONTH;

    always_comb begin
        if (i_month < C_FIRST_MONTH || i_month > C_LAST_MONTH) begin
            o_len = '0;
        end else if (i_month == C_FEB) begin
            o_len = w_leap ? C_FEB_LEAP : C_FEB_NORM;
        end else begin
            o_len = C_MONTH_LEN[w_idx];
        end
    end

endmodule

@@ tb/tb_gregorian_date_add_days.sv @@
// Self-checking bench for gregorian_date_add_days: a table of dates, then random dates.
// Untyped rows and random dates are predicted by a month walk; results checked in order.
// Depends on dadd_pkg, dadd_if and the block under test.
module tb_gregorian_date_add_days;
    import dadd_pkg::*;

    localparam int N_DIR    = 22;
    localparam int N_RANDOM = 500;

    typedef struct packed {
        logic [C_DAY_W-1:0]   day;
        logic [C_MONTH_W-1:0] month;
        logic [C_YEAR_W-1:0]  year;
        logic [C_ADD_W-1:0]   add;
    } t_date_in;

    typedef struct packed {
        logic [C_DAY_W-1:0]   day;
        logic [C_MONTH_W-1:0] month;
        logic [C_YEAR_W-1:0]  year;
    } t_date_out;

    typedef struct packed {
        t_date_in  stim;
        logic      typed;
        t_date_out want;
    } t_date_row;

    logic i_clk;
    logic i_rst_n;

    dadd_in_if  in_if();
    dadd_out_if out_if();

    t_date_out pending_dates [$];
    int        mismatches;
    int        burst_left;

    gregorian_date_add_days dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // stim {day, month, year, add}, typed, want {day, month, year}
    t_date_row dir_rows [N_DIR] = '{
        '{'{5'd1,  4'd1,  14'd2000,  15'd0},     1'b1, '{5'd1,  4'd1,  14'd2000}},
        '{'{5'd31, 4'd12, 14'd1999,  15'd1},     1'b1, '{5'd1,  4'd1,  14'd2000}},
        '{'{5'd28, 4'd2,  14'd2000,  15'd1},     1'b1, '{5'd29, 4'd2,  14'd2000}},
        '{'{5'd28, 4'd2,  14'd1900,  15'd1},     1'b1, '{5'd1,  4'd3,  14'd1900}},
        '{'{5'd28, 4'd2,  14'd2024,  15'd1},     1'b1, '{5'd29, 4'd2,  14'd2024}},
        '{'{5'd28, 4'd2,  14'd2023,  15'd1},     1'b1, '{5'd1,  4'd3,  14'd2023}},
        '{'{5'd31, 4'd2,  14'd2023,  15'd0},     1'b1, '{5'd3,  4'd3,  14'd2023}},
        '{'{5'd0,  4'd1,  14'd2023,  15'd0},     1'b1, '{5'd0,  4'd1,  14'd2023}},
        '{'{5'd0,  4'd0,  14'd2023,  15'd0},     1'b1, '{5'd0,  4'd1,  14'd2023}},
        '{'{5'd15, 4'd0,  14'd2023,  15'd0},     1'b1, '{5'd15, 4'd1,  14'd2023}},
        '{'{5'd1,  4'd13, 14'd2023,  15'd0},     1'b1, '{5'd1,  4'd1,  14'd2024}},
        '{'{5'd31, 4'd15, 14'd2024,  15'd0},     1'b1, '{5'd31, 4'd1,  14'd2025}},
        '{'{5'd1,  4'd1,  14'd0,     15'd0},     1'b1, '{5'd1,  4'd1,  14'd0}},
        '{'{5'd28, 4'd2,  14'd0,     15'd1},     1'b1, '{5'd29, 4'd2,  14'd0}},
        '{'{5'd0,  4'd0,  14'd0,     15'd0},     1'b1, '{5'd0,  4'd1,  14'd0}},
        '{'{5'd1,  4'd1,  14'd1,     15'd0},     1'b1, '{5'd1,  4'd1,  14'd1}},
        '{'{5'd1,  4'd12, 14'd2023,  15'd31},    1'b1, '{5'd1,  4'd1,  14'd2024}},
        '{'{5'd1,  4'd1,  14'd2023,  15'd365},   1'b1, '{5'd1,  4'd1,  14'd2024}},
        '{'{5'd1,  4'd1,  14'd1,     15'd32767}, 1'b0, '{5'd0,  4'd0,  14'd0}},
        '{'{5'd31, 4'd12, 14'd9999,  15'd32767}, 1'b0, '{5'd0,  4'd0,  14'd0}},
        '{'{5'd31, 4'd12, 14'd16383, 15'd32767}, 1'b0, '{5'd0,  4'd0,  14'd0}},
        '{'{5'd31, 4'd15, 14'd16383, 15'd32767}, 1'b0, '{5'd0,  4'd0,  14'd0}}
    };

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        if (m < 32'(C_FIRST_MONTH) || m > 32'(C_LAST_MONTH)) begin
            return 0;
        end
        if (m == 32'(C_FEB)) begin
            return is_leap(y) ? 32'(C_FEB_LEAP) : 32'(C_FEB_NORM);
        end
        return 32'(C_MONTH_LEN[m[C_MONTH_W-1:0] - C_FIRST_MONTH]);
    endfunction

    function automatic t_date_out add_days_to_date(input t_date_in d);
        int unsigned left;
        int unsigned m;
        int unsigned y;
        int unsigned len;
        t_date_out   r;
        left = 0;
        y    = 32'(d.year);
        for (m = 1; m < 32'(d.month); m++) begin
            left += month_days(m, y);
        end
        left += 32'(d.day) + 32'(d.add);
        m = 32'(C_FIRST_MONTH);
        len = month_days(m, y);
        while (left > len) begin
            left -= len;
            m++;
            if (m > 32'(C_LAST_MONTH)) begin
                m = 32'(C_FIRST_MONTH);
                y++;
            end
            len = month_days(m, y);
        end
        r.day   = left[C_DAY_W-1:0];
        r.month = m[C_MONTH_W-1:0];
        r.year  = y[C_YEAR_W-1:0];
        return r;
    endfunction

    function automatic t_date_in random_date();
        t_date_in    d;
        int unsigned m;
        int unsigned y;
        if ($urandom_range(0, 6) == 0) begin
            d.day   = C_DAY_W'($urandom_range(0, 31));
            d.month = C_MONTH_W'($urandom_range(0, 15));
            d.year  = C_YEAR_W'($urandom_range(0, 16383));
        end else begin
            m       = $urandom_range(1, 12);
            y       = ($urandom_range(0, 3) == 0) ? 400 * $urandom_range(0, 24)
                                                  : $urandom_range(1, 9999);
            d.month = m[C_MONTH_W-1:0];
            d.year  = y[C_YEAR_W-1:0];
            d.day   = C_DAY_W'($urandom_range(1, month_days(m, y)));
        end
        case ($urandom_range(0, 4))
            0: d.add = C_ADD_W'($urandom_range(0, 400));
            1: d.add = ($urandom_range(0, 1) == 0) ? 15'd0 : 15'd32767;
            default: d.add = C_ADD_W'($urandom_range(0, 32767));
        endcase
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_date(input t_date_in d, input t_date_out want);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1500) : $urandom_range(1, 20);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        in_if.valid       <= 1'b1;
        in_if.start_day   <= d.day;
        in_if.start_month <= d.month;
        in_if.start_year  <= d.year;
        in_if.days_to_add <= d.add;
        do @(posedge i_clk); while (!in_if.ready);
        pending_dates.push_back(want);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    always begin
        #10 i_clk = ~i_clk;
    end

    initial begin
        i_clk = 1'b0;
    end

    initial begin
        #150_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int stall_left;
        int phase_cycles;
        int stall_max;
        stall_left   = 0;
        phase_cycles = 0;
        stall_max    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_cycles == 0) begin
                phase_cycles = $urandom_range(500, 3000);
                stall_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end
            phase_cycles--;
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (stall_max != 0 && $urandom_range(0, 2) == 0) begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(0, stall_max - 1);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_date_out want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                    out_if.result_day, out_if.result_month, out_if.result_year));
            end else begin
                want = pending_dates.pop_front();
                if (out_if.result_day !== want.day || out_if.result_month !== want.month ||
                    out_if.result_year !== want.year) begin
                    report_mismatch($sformatf("got %0d/%0d/%0d, want %0d/%0d/%0d",
                        out_if.result_day, out_if.result_month, out_if.result_year,
                        want.day, want.month, want.year));
                end
            end
        end
    end

    initial begin
        t_date_in  d;
        t_date_out want;
        mismatches        = 0;
        burst_left        = 0;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.start_day   = '0;
        in_if.start_month = '0;
        in_if.start_year  = '0;
        in_if.days_to_add = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            d    = dir_rows[i].stim;
            want = dir_rows[i].typed ? dir_rows[i].want : add_days_to_date(d);
            send_date(d, want);
        end
        hold_until_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                hold_until_drained();
            end
            d = random_date();
            send_date(d, add_days_to_date(d));
        end
        hold_until_drained();
        repeat (1200) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/dadd_pkg.sv
rtl/core/dadd_if.sv
rtl/core/dadd_alu.sv
rtl/core/dadd_mlen.sv
rtl/core/gregorian_date_add_days.sv
tb/tb_gregorian_date_add_days.sv
